/* rtl/torus_vertex_generator_core_assert.svh */
// ----------------------------------------------------------------------------
// Torus vertex generator assertion macros
// Concurrent assertion helpers clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TORUS_VERTEX_GENERATOR_CORE_ASSERT_SVH
`define TORUS_VERTEX_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTH
`define TVG_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
`define TVG_ASSERT_DELAY(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("assertion failed");
`else
`define TVG_ASSERT_IMPLY(label, ante, cons)
`define TVG_ASSERT_DELAY(label, ante, n, cons)
`endif

`endif

/* rtl/tvg_pkg.sv */
// ----------------------------------------------------------------------------
// Torus vertex generator package
// Field widths, register indexes, pipeline sideband type and helper functions.
// ----------------------------------------------------------------------------
package tvg_pkg;

   localparam int IdxWidth   = 12;
   localparam int SampWidth  = 13;
   localparam int FracWidth  = 16;
   localparam int RadWidth   = 16;
   localparam int PosWidth   = 18;
   localparam int IdWidth    = 32;
   localparam int TrigWidth  = 17;
   localparam int MagWidth   = 16;
   localparam int ProdWidth  = 51;
   localparam int MaxSamples = 4096;

   typedef enum logic [1:0] {
      CSR_LARGE_RADIUS = 2'd0,
      CSR_SMALL_RADIUS = 2'd1,
      CSR_RING_SAMPLES = 2'd2,
      CSR_TUBE_SAMPLES = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 valid;
      logic                 index_error;
      logic [IdWidth-1:0]   id;
      logic [FracWidth-1:0] tex_u;
      logic [FracWidth-1:0] tex_v;
   } side_type;

   // Quarter-wave sine entry in Q1.15, evaluated by a Taylor series in Q2.30.
   function automatic logic [MagWidth-1:0] sine_entry(int unsigned k, int unsigned bits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] r;
      x    = (64'(k) * 64'd1686629713) >> bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 7; n++) begin
         term = (term * x2) >> 30;
         case (n)
            1:       term = term / 64'd6;
            2:       term = term / 64'd20;
            3:       term = term / 64'd42;
            4:       term = term / 64'd72;
            5:       term = term / 64'd110;
            6:       term = term / 64'd156;
            default: term = term / 64'd210;
         endcase
         if ((n & 1) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      r = (sum + 64'sd16384) >>> 15;
      if (r > 64'sd32768) begin
         r = 64'sd32768;
      end
      return MagWidth'(r);
   endfunction

   // Shift right with rounding half away from zero, then saturate to Q10.8.
   function automatic logic signed [PosWidth-1:0] round_sat(logic signed [ProdWidth-1:0] v,
                                                            int unsigned s);
      logic                 neg;
      logic [ProdWidth-1:0] mag;
      logic [ProdWidth-1:0] rnd;
      logic signed [PosWidth-1:0] res;
      neg = v[ProdWidth-1];
      mag = neg ? ProdWidth'(-v) : ProdWidth'(v);
      rnd = (mag + (ProdWidth'(1) << (s - 1))) >> s;
      if (neg) begin
         res = (rnd >= ProdWidth'(131072)) ? -18'sd131072 : -$signed(PosWidth'(rnd));
      end else begin
         res = (rnd >= ProdWidth'(131071)) ? 18'sd131071 : $signed(PosWidth'(rnd));
      end
      return res;
   endfunction

endpackage

/* rtl/tvg_div.sv */
// ----------------------------------------------------------------------------
// Torus vertex generator fraction divider
// Restoring divider, one quotient bit per stage: (index << 16) / samples.
// ----------------------------------------------------------------------------
module tvg_div (
   input  logic                           clock,
   input  logic [tvg_pkg::IdxWidth-1:0]   dividend,
   input  logic [tvg_pkg::SampWidth-1:0]  divisor,
   output logic [tvg_pkg::FracWidth-1:0]  quotient
);
   import tvg_pkg::*;

   localparam int Steps = FracWidth;

   logic [SampWidth-1:0] rem_ff [Steps];
   logic [SampWidth-1:0] div_ff [Steps];
   logic [FracWidth-1:0] quo_ff [Steps];

   for (genvar j = 0; j < Steps; j++) begin : g_step
      logic [SampWidth-1:0] src_rem;
      logic [SampWidth-1:0] src_div;
      logic [FracWidth-1:0] src_quo;
      logic [SampWidth:0]   rem2;
      logic                 ge;

      if (j == 0) begin : g_first
         assign src_rem = SampWidth'(dividend);
         assign src_div = divisor;
         assign src_quo = '0;
      end else begin : g_next
         assign src_rem = rem_ff[j-1];
         assign src_div = div_ff[j-1];
         assign src_quo = quo_ff[j-1];
      end

      assign rem2 = {src_rem, 1'b0};
      assign ge   = rem2 >= {1'b0, src_div};

      always_ff @(posedge clock) begin
         rem_ff[j] <= ge ? SampWidth'(rem2 - {1'b0, src_div}) : SampWidth'(rem2);
         div_ff[j] <= src_div;
         quo_ff[j] <= {src_quo[FracWidth-2:0], ge};
      end
   end

   assign quotient = quo_ff[Steps-1];

endmodule

/* rtl/tvg_sincos.sv */
// ----------------------------------------------------------------------------
// Torus vertex generator sine and cosine lookup
// Turns a Q0.16 fraction into a phase and reads a quarter-wave table; the table address and the result are registered.
// ----------------------------------------------------------------------------
module tvg_sincos #(
   parameter int TableBits = 10
) (
   input  logic                                clock,
   input  logic [tvg_pkg::FracWidth-1:0]       frac,
   output logic signed [tvg_pkg::TrigWidth-1:0] sin_val,
   output logic signed [tvg_pkg::TrigWidth-1:0] cos_val
);
   import tvg_pkg::*;

   localparam int Depth  = (1 << TableBits) + 1;
   localparam int PhaseW = TableBits + 2;
   localparam int Shift  = 14 - TableBits;
   localparam logic [FracWidth:0] RoundBias = (FracWidth + 1)'((1 << Shift) >> 1);
   localparam logic [TableBits:0] Quarter   = (TableBits + 1)'(1 << TableBits);

   typedef logic [MagWidth-1:0] rom_type [Depth];

   function automatic rom_type build_rom();
      rom_type rom;
      for (int k = 0; k < Depth; k++) begin
         rom[k] = sine_entry(k, TableBits);
      end
      return rom;
   endfunction

   localparam rom_type SineRom = build_rom();

   logic [FracWidth:0]  rounded;
   logic [PhaseW-1:0]   sin_phase;
   logic [PhaseW-1:0]   cos_phase;
   logic [TableBits:0]  sin_addr_in;
   logic [TableBits:0]  cos_addr_in;

   logic [TableBits:0]  sin_addr_ff;
   logic [TableBits:0]  cos_addr_ff;
   logic                sin_neg_ff;
   logic                cos_neg_ff;
   logic signed [TrigWidth-1:0] sin_ff;
   logic signed [TrigWidth-1:0] cos_ff;

   assign rounded   = {1'b0, frac} + RoundBias;
   assign sin_phase = PhaseW'(rounded >> Shift);
   assign cos_phase = sin_phase + PhaseW'(Quarter);

   // Odd quadrants mirror the table index.
   assign sin_addr_in = sin_phase[TableBits] ? Quarter - {1'b0, sin_phase[TableBits-1:0]}
                                             : {1'b0, sin_phase[TableBits-1:0]};
   assign cos_addr_in = cos_phase[TableBits] ? Quarter - {1'b0, cos_phase[TableBits-1:0]}
                                             : {1'b0, cos_phase[TableBits-1:0]};

   always_ff @(posedge clock) begin
      sin_addr_ff <= sin_addr_in;
      cos_addr_ff <= cos_addr_in;
      sin_neg_ff  <= sin_phase[TableBits+1];
      cos_neg_ff  <= cos_phase[TableBits+1];
      sin_ff <= sin_neg_ff ? -$signed({1'b0, SineRom[sin_addr_ff]})
                           :  $signed({1'b0, SineRom[sin_addr_ff]});
      cos_ff <= cos_neg_ff ? -$signed({1'b0, SineRom[cos_addr_ff]})
                           :  $signed({1'b0, SineRom[cos_addr_ff]});
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

/* rtl/torus_vertex_generator_core.sv */
// ----------------------------------------------------------------------------
// Torus vertex generator core
// Computes one parametric torus vertex per request.
// ----------------------------------------------------------------------------
// A request (tube index, ring index, object id) is accepted at any clock edge
// with start high; busy stays low because the pipeline never stalls, so one
// request can enter every cycle. Each request gives exactly one response on
// the rsp_ ports, marked by rsp_strobe for one cycle. The depth is set by the
// index input registers, the 16-stage restoring dividers that form the
// texture fractions, then the registered sine table read and four multiply
// and rounding stages. The receiver cannot stall; responses leave in request
// order. The user must write registers through the csr_ port only while no
// request is in flight; the block itself does not enforce this. Reset clears
// the valid line and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module torus_vertex_generator_core #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [tvg_pkg::IdxWidth-1:0]         req_tube_index,
   input  logic [tvg_pkg::IdxWidth-1:0]         req_ring_index,
   input  logic [tvg_pkg::IdWidth-1:0]          req_object_id,
   output logic                                 rsp_strobe,
   output logic signed [tvg_pkg::PosWidth-1:0]  rsp_pos_x,
   output logic signed [tvg_pkg::PosWidth-1:0]  rsp_pos_y,
   output logic signed [tvg_pkg::PosWidth-1:0]  rsp_pos_z,
   output logic [tvg_pkg::FracWidth-1:0]        rsp_tex_u,
   output logic [tvg_pkg::FracWidth-1:0]        rsp_tex_v,
   output logic [tvg_pkg::IdWidth-1:0]          rsp_vertex_id,
   output logic                                 rsp_index_error,
   input  logic                                 csr_write_enable,
   input  tvg_pkg::csr_index_type               csr_index,
   input  logic [tvg_pkg::RadWidth-1:0]         csr_write_data
);
   import tvg_pkg::*;

`include "torus_vertex_generator_core_assert.svh"

   localparam int DivEnd  = FracWidth + 1; // tap holding the quotients
   localparam int Taps    = DivEnd + 5;
   localparam int Latency = Taps + 1;

   logic [RadWidth-1:0]  large_radius_ff;
   logic [RadWidth-1:0]  small_radius_ff;
   logic [SampWidth-1:0] ring_samples_ff;
   logic [SampWidth-1:0] tube_samples_ff;

   logic                 accept;
   logic                 error_in;
   logic [IdxWidth-1:0]  tube_index_ff;
   logic [IdxWidth-1:0]  ring_index_ff;
   side_type             side_ff [Taps];
   side_type             side_in;
   side_type             tex_in;

   logic [FracWidth-1:0] quo_u;
   logic [FracWidth-1:0] quo_v;
   logic signed [TrigWidth-1:0] sin_u;
   logic signed [TrigWidth-1:0] cos_u;
   logic signed [TrigWidth-1:0] sin_v;
   logic signed [TrigWidth-1:0] cos_v;

   logic signed [2*TrigWidth-1:0] rcos_ff;
   logic signed [2*TrigWidth-1:0] rsin_ff;
   logic signed [TrigWidth-1:0]   cos_u_ff;
   logic signed [TrigWidth-1:0]   sin_u_ff;
   logic signed [2*TrigWidth-1:0] w_ff;
   logic signed [PosWidth-1:0]    y_ff;
   logic signed [TrigWidth-1:0]   cos_u2_ff;
   logic signed [TrigWidth-1:0]   sin_u2_ff;
   logic signed [ProdWidth-1:0]   px_ff;
   logic signed [ProdWidth-1:0]   pz_ff;
   logic signed [PosWidth-1:0]    y2_ff;

   logic                          rsp_strobe_ff;
   logic signed [PosWidth-1:0]    pos_x_ff;
   logic signed [PosWidth-1:0]    pos_y_ff;
   logic signed [PosWidth-1:0]    pos_z_ff;
   logic [FracWidth-1:0]          tex_u_ff;
   logic [FracWidth-1:0]          tex_v_ff;
   logic [IdWidth-1:0]            vertex_id_ff;
   logic                          index_error_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         large_radius_ff <= RadWidth'(256);
         small_radius_ff <= RadWidth'(64);
         ring_samples_ff <= SampWidth'(32);
         tube_samples_ff <= SampWidth'(16);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LARGE_RADIUS: large_radius_ff <= csr_write_data;
            CSR_SMALL_RADIUS: small_radius_ff <= csr_write_data;
            CSR_RING_SAMPLES: ring_samples_ff <= SampWidth'(csr_write_data);
            CSR_TUBE_SAMPLES: tube_samples_ff <= SampWidth'(csr_write_data);
         endcase
      end
   end

   assign error_in = ({1'b0, req_tube_index} >= tube_samples_ff) ||
                     ({1'b0, req_ring_index} >= ring_samples_ff) ||
                     (32'(req_tube_index) >= 32'(MaxSamples)) ||
                     (32'(req_ring_index) >= 32'(MaxSamples));

   always_comb begin
      side_in             = '0;
      side_in.valid       = accept;
      side_in.index_error = error_in;
      side_in.id          = req_object_id;
   end

   // The quotients join the sideband at the tap after the dividers.
   always_comb begin
      tex_in       = side_ff[DivEnd-1];
      tex_in.tex_u = quo_u;
      tex_in.tex_v = quo_v;
   end

   always_ff @(posedge clock) begin
      tube_index_ff <= req_tube_index;
      ring_index_ff <= req_ring_index;
   end

   for (genvar t = 0; t < Taps; t++) begin : g_tap
      always_ff @(posedge clock) begin
         if (reset) begin
            side_ff[t] <= '0;
         end else if (t == 0) begin
            side_ff[t] <= side_in;
         end else if (t == DivEnd) begin
            side_ff[t] <= tex_in;
         end else begin
            side_ff[t] <= side_ff[t-1];
         end
      end
   end

   tvg_div u_div_u (
      .clock    (clock),
      .dividend (ring_index_ff),
      .divisor  (ring_samples_ff),
      .quotient (quo_u)
   );

   tvg_div u_div_v (
      .clock    (clock),
      .dividend (tube_index_ff),
      .divisor  (tube_samples_ff),
      .quotient (quo_v)
   );

   tvg_sincos #(.TableBits(SINE_TABLE_BITS)) u_trig_u (
      .clock   (clock),
      .frac    (quo_u),
      .sin_val (sin_u),
      .cos_val (cos_u)
   );

   tvg_sincos #(.TableBits(SINE_TABLE_BITS)) u_trig_v (
      .clock   (clock),
      .frac    (quo_v),
      .sin_val (sin_v),
      .cos_val (cos_v)
   );

   // Multiply stages: r*cos v and r*sin v, then w and the rounded y, then w*cos u and w*sin u.
   always_ff @(posedge clock) begin
      rcos_ff   <= $signed({1'b0, small_radius_ff}) * cos_v;
      rsin_ff   <= $signed({1'b0, small_radius_ff}) * sin_v;
      cos_u_ff  <= cos_u;
      sin_u_ff  <= sin_u;

      w_ff      <= $signed({3'b000, large_radius_ff, 15'd0}) + rcos_ff;
      y_ff      <= round_sat(ProdWidth'(rsin_ff), 15);
      cos_u2_ff <= cos_u_ff;
      sin_u2_ff <= sin_u_ff;

      px_ff     <= w_ff * cos_u2_ff;
      pz_ff     <= w_ff * sin_u2_ff;
      y2_ff     <= y_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= side_ff[Taps-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (side_ff[Taps-1].index_error) begin
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         pos_z_ff <= '0;
         tex_u_ff <= '0;
         tex_v_ff <= '0;
      end else begin
         pos_x_ff <= round_sat(px_ff, 30);
         pos_y_ff <= y2_ff;
         pos_z_ff <= round_sat(pz_ff, 30);
         tex_u_ff <= side_ff[Taps-1].tex_u;
         tex_v_ff <= side_ff[Taps-1].tex_v;
      end
      vertex_id_ff   <= side_ff[Taps-1].id;
      index_error_ff <= side_ff[Taps-1].index_error;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_pos_x       = pos_x_ff;
   assign rsp_pos_y       = pos_y_ff;
   assign rsp_pos_z       = pos_z_ff;
   assign rsp_tex_u       = tex_u_ff;
   assign rsp_tex_v       = tex_v_ff;
   assign rsp_vertex_id   = vertex_id_ff;
   assign rsp_index_error = index_error_ff;

   `TVG_ASSERT_DELAY(a_latency, accept, 23, rsp_strobe)
   `TVG_ASSERT_DELAY(a_index_range, accept && error_in, 23, rsp_index_error)
   `TVG_ASSERT_IMPLY(a_error_zero, rsp_strobe && rsp_index_error, (rsp_pos_x | rsp_pos_y) == '0)
   `TVG_ASSERT_IMPLY(a_error_zero_z, rsp_strobe && rsp_index_error, rsp_pos_z == '0)
   `TVG_ASSERT_IMPLY(a_depth, side_ff[Taps-1].valid, Latency == 23)

endmodule

/* sim/torus_vertex_generator_core_tb.sv */
// ----------------------------------------------------------------------------
// Torus vertex generator core testbench
// Sends grid point requests in random bursts over several radius and sample
// count settings, and checks every vertex against a fixed-point predictor or a directed expected vertex.
// ----------------------------------------------------------------------------
module torus_vertex_generator_core_tb;
   import tvg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QuarterN    = 1024;
   localparam int CycleLimit  = 300000;
   localparam int NumPhases   = 10;
   localparam int RandPerItem = 135;

   typedef struct packed {
      logic signed [PosWidth-1:0] pos_x;
      logic signed [PosWidth-1:0] pos_y;
      logic signed [PosWidth-1:0] pos_z;
      logic [FracWidth-1:0]       tex_u;
      logic [FracWidth-1:0]       tex_v;
      logic [IdWidth-1:0]         vertex_id;
      logic                       index_error;
   } vertex_type;

   typedef struct {
      logic [IdxWidth-1:0] tube;
      logic [IdxWidth-1:0] ring;
      logic [IdWidth-1:0]  id;
      bit                  typed;
      vertex_type          vtx;
   } row_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [IdxWidth-1:0]    req_tube_index;
   logic [IdxWidth-1:0]    req_ring_index;
   logic [IdWidth-1:0]     req_object_id;
   logic                   rsp_strobe;
   logic signed [PosWidth-1:0] rsp_pos_x;
   logic signed [PosWidth-1:0] rsp_pos_y;
   logic signed [PosWidth-1:0] rsp_pos_z;
   logic [FracWidth-1:0]   rsp_tex_u;
   logic [FracWidth-1:0]   rsp_tex_v;
   logic [IdWidth-1:0]     rsp_vertex_id;
   logic                   rsp_index_error;
   logic                   csr_write_enable;
   csr_index_type          csr_index;
   logic [RadWidth-1:0]    csr_write_data;

   longint unsigned sine_lut [0:QuarterN];
   logic [RadWidth-1:0]  big_r, tube_r;
   logic [SampWidth-1:0] ring_n, tube_n;

   vertex_type vertex_queue[$];
   bit         next_typed;
   vertex_type next_vtx;
   int         mismatches;
   int         vertices_checked;
   int         errors_seen;
   int         cycles;

   torus_vertex_generator_core dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Quarter-wave sine in Q1.15 from a Taylor series in Q2.30.
   initial begin
      longint unsigned x, x2, term;
      longint sum, r;
      for (int k = 0; k <= QuarterN; k++) begin
         x    = (longint'(k) * 64'd1686629713) >> 10;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         r = (sum + 16384) >>> 15;
         if (r > 32768) r = 32768;
         sine_lut[k] = r;
      end
   end

   function automatic longint sine_of(int unsigned p);
      int unsigned q, k;
      longint v;
      q = (p >> 10) & 3;
      k = p & (QuarterN - 1);
      v = longint'(sine_lut[(q & 1) ? QuarterN - k : k]);
      return (q & 2) ? -v : v;
   endfunction

   function automatic logic signed [PosWidth-1:0] scale_round(longint v, int unsigned s);
      longint unsigned m;
      longint r;
      m = (v < 0) ? longint'(-v) : longint'(v);
      m = (m + (64'd1 << (s - 1))) >> s;
      if (m > 131072) m = 131072;
      r = (v < 0) ? -longint'(m) : longint'(m);
      if (r > 131071) r = 131071;
      return PosWidth'(r);
   endfunction

   function automatic vertex_type torus_vertex(logic [IdxWidth-1:0] ti,
                                               logic [IdxWidth-1:0] ri,
                                               logic [IdWidth-1:0] id);
      vertex_type vtx;
      int unsigned fu, fv, pu, pv;
      longint w;
      vtx = '0;
      vtx.vertex_id = id;
      if (ti >= tube_n || ri >= ring_n) begin
         vtx.index_error = 1'b1;
         return vtx;
      end
      fu = (int'(ri) << 16) / int'(ring_n);
      fv = (int'(ti) << 16) / int'(tube_n);
      pu = ((fu + 8) >> 4) & 4095;
      pv = ((fv + 8) >> 4) & 4095;
      w = longint'(big_r) * 32768 + longint'(tube_r) * sine_of((pv + QuarterN) & 4095);
      vtx.pos_x = scale_round(w * sine_of((pu + QuarterN) & 4095), 30);
      vtx.pos_z = scale_round(w * sine_of(pu), 30);
      vtx.pos_y = scale_round(longint'(tube_r) * sine_of(pv), 15);
      vtx.tex_u = FracWidth'(fu);
      vtx.tex_v = FracWidth'(fv);
      return vtx;
   endfunction

   // Shadow registers and the expected vertex store follow the accepted traffic.
   always @(posedge clock) begin
      vertex_type vtx;
      if (reset) begin
         big_r  <= 16'd256;
         tube_r <= 16'd64;
         ring_n <= 13'd32;
         tube_n <= 13'd16;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_LARGE_RADIUS: big_r  <= csr_write_data;
               CSR_SMALL_RADIUS: tube_r <= csr_write_data;
               CSR_RING_SAMPLES: ring_n <= SampWidth'(csr_write_data);
               CSR_TUBE_SAMPLES: tube_n <= SampWidth'(csr_write_data);
               default: ;
            endcase
         end
         if (start && !busy) begin
            vtx = next_typed ? next_vtx
                             : torus_vertex(req_tube_index, req_ring_index, req_object_id);
            vertex_queue = {vertex_queue, vtx};
         end
         if (rsp_strobe) begin
            if (vertex_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected vertex, id %h", rsp_vertex_id);
            end else begin
               vtx = vertex_queue.pop_front();
               vertices_checked++;
               if (rsp_index_error) errors_seen++;
               if ({rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_tex_u, rsp_tex_v, rsp_vertex_id,
                    rsp_index_error} !== vtx) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("Mismatch exp x %0d y %0d z %0d u %h v %h id %h err %b",
                              vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.tex_u, vtx.tex_v,
                              vtx.vertex_id, vtx.index_error);
                     $display("         got x %0d y %0d z %0d u %h v %h id %h err %b",
                              rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_tex_u, rsp_tex_v,
                              rsp_vertex_id, rsp_index_error);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   int burst_left;

   task automatic send_request(logic [IdxWidth-1:0] ti, logic [IdxWidth-1:0] ri,
                               logic [IdWidth-1:0] id, bit typed, vertex_type vtx);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      end
      burst_left--;
      req_tube_index <= ti;
      req_ring_index <= ri;
      req_object_id  <= id;
      next_typed     <= typed;
      next_vtx       <= vtx;
      start          <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Leaves the write enable high; the caller drops it after the last write.
   task automatic write_csr(csr_index_type idx, logic [RadWidth-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (vertex_queue.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   initial begin
      row_type rows[$];
      row_type row;
      vertex_type none;
      logic [RadWidth-1:0] cfg [4];
      int lim;
      logic [IdxWidth-1:0] ti, ri;
      none             = '0;
      mismatches       = 0;
      vertices_checked = 0;
      errors_seen      = 0;
      cycles           = 0;
      burst_left       = 0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_tube_index   <= '0;
      req_ring_index   <= '0;
      req_object_id    <= '0;
      next_typed       <= 1'b0;
      next_vtx         <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= CSR_LARGE_RADIUS;
      csr_write_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under the reset register values.
      rows = '{
         '{12'd0,    12'd0,  32'h0000_0000, 1'b1, '{18'sd320, 18'sd0, 18'sd0,
                                                  16'h0000, 16'h0000, 32'h0000_0000, 1'b0}},
         '{12'd0,    12'd8,  32'hFFFF_FFFF, 1'b1, '{18'sd0, 18'sd0, 18'sd320,
                                                  16'h4000, 16'h0000, 32'hFFFF_FFFF, 1'b0}},
         '{12'd16,   12'd0,  32'h1234_5678, 1'b1, '{18'sd0, 18'sd0, 18'sd0,
                                                  16'h0000, 16'h0000, 32'h1234_5678, 1'b1}},
         '{12'd0,    12'd32, 32'h8000_0001, 1'b1, '{18'sd0, 18'sd0, 18'sd0,
                                                  16'h0000, 16'h0000, 32'h8000_0001, 1'b1}},
         '{12'd4095, 12'd4095, 32'hA5A5_5A5A, 1'b1, '{18'sd0, 18'sd0, 18'sd0,
                                                  16'h0000, 16'h0000, 32'hA5A5_5A5A, 1'b1}},
         '{12'd15,   12'd31, 32'h0000_0001, 1'b0, '0},
         '{12'd4,    12'd0,  32'h0000_0002, 1'b0, '0},
         '{12'd12,   12'd16, 32'h0000_0003, 1'b0, '0},
         '{12'd8,    12'd24, 32'h0000_0004, 1'b0, '0},
         '{12'd1,    12'd1,  32'h0000_0005, 1'b0, '0}
      };
      foreach (rows[i]) begin
         row = rows[i];
         send_request(row.tube, row.ring, row.id, row.typed, row.vtx);
      end

      for (int phase = 0; phase < NumPhases; phase++) begin
         drain();
         case (phase)
            0: cfg = '{16'd256, 16'd64, 16'd32, 16'd16};
            1: cfg = '{16'hFFFF, 16'hFFFF, 16'd4096, 16'd4096}; // saturating coordinates
            2: cfg = '{16'd0, 16'd0, 16'd1, 16'd1};
            3: cfg = '{16'd100, 16'h0200, 16'd0, 16'd7};        // zero ring count
            4: cfg = '{16'h4000, 16'h0100, 16'hE00C, 16'd0};    // upper data bits dropped
            5: cfg = '{16'h1FFF, 16'h1FFF, 16'd8191, 16'd4097}; // counts above 4096
            default: cfg = '{16'($urandom_range(0, 65535)), 16'($urandom_range(0, 20000)),
                             16'($urandom_range(1, 4096)), 16'($urandom_range(1, 300))};
         endcase
         write_csr(CSR_LARGE_RADIUS, cfg[0]);
         write_csr(CSR_SMALL_RADIUS, cfg[1]);
         write_csr(CSR_RING_SAMPLES, cfg[2]);
         write_csr(CSR_TUBE_SAMPLES, cfg[3]);
         csr_write_enable <= 1'b0;
         @(posedge clock);
         if (phase == 2) begin
            send_request(12'hFFF, 12'hFFF, 32'hDEAD_BEEF, 1'b1,
                         '{18'sd0, 18'sd0, 18'sd0, 16'h0000, 16'h0000, 32'hDEAD_BEEF, 1'b1});
         end
         for (int n = 0; n < RandPerItem; n++) begin
            ti = IdxWidth'($urandom_range(0, 4095));
            ri = IdxWidth'($urandom_range(0, 4095));
            // Mostly in-range grid points, with some out-of-range noise.
            if ($urandom_range(0, 9) < 8) begin
               lim = (tube_n > 4096) ? 4096 : int'(tube_n);
               if (lim > 0) ti = IdxWidth'($urandom_range(0, lim - 1));
               lim = (ring_n > 4096) ? 4096 : int'(ring_n);
               if (lim > 0) ri = IdxWidth'($urandom_range(0, lim - 1));
            end
            send_request(ti, ri, $urandom, 1'b0, none);
         end
      end
      drain();
      $display("Checked %0d vertices over %0d register settings, %0d with index errors.",
               vertices_checked, NumPhases + 1, errors_seen);
      if (mismatches == 0 && vertex_queue.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("Mismatches: %0d, vertices still expected: %0d", mismatches,
                  vertex_queue.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
